// File: sv/fdc_pkg.sv
// Shared types, constants and command tables for the floppy controller unit.
`timescale 1ns / 1ps

package fdc_pkg;

  // Disk image geometry
  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int IMG_AW       = 21;
  localparam int LBA_W        = IMG_AW - SECTOR_SHIFT;

  // Command collection
  localparam int CMD_DEPTH = 9;
  localparam int RES_DEPTH = 7;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Port offsets
  localparam logic [7:0] P_ID    = 8'h18;
  localparam logic [7:0] P_DMA0  = 8'h80;
  localparam logic [7:0] P_DMA1  = 8'h88;
  localparam logic [7:0] P_CTRL  = 8'h90;
  localparam logic [7:0] P_IRQ   = 8'h98;
  localparam logic [7:0] P_STAT  = 8'hA0;
  localparam logic [7:0] P_DATA  = 8'hA8;
  localparam logic [7:0] P_ZERO  = 8'hB8;

  // Fixed read values and status bits
  localparam logic [7:0] ID_VALUE  = 8'h8F;
  localparam logic [7:0] CTRL_READ = 8'h40;
  localparam logic [7:0] IRQ_READ  = 8'h40;
  localparam logic [7:0] MS_RQM    = 8'h80;
  localparam logic [7:0] MS_DIO    = 8'h40;
  localparam logic [7:0] ST0_INVAL = 8'h80;
  localparam logic [7:0] ST0_SENSE0 = 8'hC0;
  localparam logic [7:0] ST0_SENSEN = 8'h60;

  // Configuration
  localparam logic       CFG_SPT = 1'b0;
  localparam logic       CFG_CYL = 1'b1;
  localparam logic [5:0] SPT_RESET = 6'd18;
  localparam logic [7:0] CYL_RESET = 8'd80;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_COMMAND   = 2'd1,
    PH_EXECUTION = 2'd2,
    PH_RESULT    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE      = 3'd0,
    K_INVALID   = 3'd1,
    K_READ_DATA = 3'd2,
    K_SENSE_INT = 3'd3,
    K_SEEK      = 3'd4,
    K_READ_ID   = 3'd5
  } kind_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] port;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              claimed;
    logic              disk_fetch;
    logic [IMG_AW-1:0] disk_address;
    logic              irq_line;
  } res_t;

  // What a completed command does to the controller state
  typedef struct packed {
    logic [RES_DEPTH-1:0][7:0] res_bytes;
    logic [7:0]                pcyl;
    logic                      ptr_load;
    logic [IMG_AW-1:0]         ptr;
  } exec_t;

  // Number of command bytes per opcode
  function automatic logic [3:0] wr_len(input logic [4:0] code);
    logic [3:0] len;
    case (code)
      5'h02, 5'h05, 5'h06, 5'h09, 5'h0C, 5'h11, 5'h19, 5'h1D: len = 4'd9;
      5'h03, 5'h0F: len = 4'd3;
      5'h04, 5'h07, 5'h0A: len = 4'd2;
      5'h0D: len = 4'd6;
      default: len = 4'd1;
    endcase
    return len;
  endfunction

  // Number of result bytes per opcode
  function automatic logic [2:0] rd_len(input logic [4:0] code);
    logic [2:0] len;
    case (code)
      5'h02, 5'h05, 5'h06, 5'h09, 5'h0A, 5'h0C, 5'h0D, 5'h11, 5'h19, 5'h1D: len = 3'd7;
      5'h03, 5'h07, 5'h0F: len = 3'd0;
      5'h08: len = 3'd2;
      default: len = 3'd1;
    endcase
    return len;
  endfunction

  // Execution behavior per opcode
  function automatic kind_t cmd_kind(input logic [4:0] code);
    kind_t k;
    case (code)
      5'h02, 5'h03, 5'h04, 5'h05, 5'h07, 5'h09, 5'h0C, 5'h0D, 5'h11, 5'h19, 5'h1D:
        k = K_NONE;
      5'h06: k = K_READ_DATA;
      5'h08: k = K_SENSE_INT;
      5'h0A: k = K_READ_ID;
      5'h0F: k = K_SEEK;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

endpackage

// File: sv/fdc_exec.sv
// Command execution: result bytes, seek target and Read Data sector address.
`timescale 1ns / 1ps

module fdc_exec (
  input  logic [4:0]                         code,
  input  logic [5:0]                         spt,
  input  logic [7:0]                         cyl_count,
  input  logic [1:0]                         dsel,
  input  logic [7:0]                         pcyl,
  input  logic [fdc_pkg::RES_DEPTH-1:0][7:0] res_cur,
  input  logic [7:0]                         byte_c,
  input  logic [7:0]                         byte_h,
  input  logic [7:0]                         byte_r,
  input  logic [7:0]                         byte_n,
  output fdc_pkg::exec_t                     ex
);

  fdc_pkg::kind_t                kind;
  logic [9:0]                    track;
  logic [15:0]                   prod;
  logic [16:0]                   lba_sum;
  logic [fdc_pkg::LBA_W-1:0]     lba;
  logic [7:0]                    c_nx;
  logic [7:0]                    h_nx;
  logic [7:0]                    r_nx;

  assign kind = fdc_pkg::cmd_kind(code);

  // Sector address: ((H + 2C) * spt + R - 1) * sector size, image-wrapped
  assign track   = 10'(byte_h) + {1'b0, byte_c, 1'b0};
  assign prod    = 16'(track) * 16'(spt);
  assign lba_sum = {1'b0, prod} + 17'(byte_r) - 17'd1;
  assign lba     = lba_sum[fdc_pkg::LBA_W-1:0];

  // Next sector: R, then head, then cylinder wrap
  always_comb begin
    c_nx = byte_c;
    h_nx = byte_h;
    r_nx = byte_r + 8'd1;
    if (r_nx == ({2'b00, spt} + 8'd1)) begin
      r_nx = 8'd1;
      h_nx = byte_h + 8'd1;
      if (h_nx == 8'd2) begin
        h_nx = 8'd0;
        c_nx = byte_c + 8'd1;
        if (c_nx == cyl_count) begin
          c_nx = 8'd0;
        end
      end
    end
  end

  // Effect of the command on the result bytes and drive state
  always_comb begin
    ex.res_bytes = res_cur;
    ex.pcyl      = pcyl;
    ex.ptr_load  = 1'b0;
    ex.ptr       = {lba, {fdc_pkg::SECTOR_SHIFT{1'b0}}};
    case (kind)
      fdc_pkg::K_INVALID: begin
        ex.res_bytes[0] = fdc_pkg::ST0_INVAL;
      end
      fdc_pkg::K_READ_DATA: begin
        ex.ptr_load     = 1'b1;
        ex.res_bytes[0] = 8'h00;
        ex.res_bytes[1] = 8'h00;
        ex.res_bytes[2] = 8'h00;
        ex.res_bytes[3] = c_nx;
        ex.res_bytes[4] = h_nx;
        ex.res_bytes[5] = r_nx;
        ex.res_bytes[6] = byte_n;
      end
      fdc_pkg::K_SENSE_INT: begin
        ex.res_bytes[0] = (dsel == 2'd0) ? fdc_pkg::ST0_SENSE0 : fdc_pkg::ST0_SENSEN;
        ex.res_bytes[1] = pcyl;
      end
      fdc_pkg::K_SEEK: begin
        ex.pcyl = byte_c;
      end
      fdc_pkg::K_READ_ID: begin
        ex.res_bytes[0] = 8'h00;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/floppy_controller_command_result_unit.sv
// Top level: bus-port front end of a 765-style floppy controller.
`timescale 1ns / 1ps

// One bus access per request. A request taken at a start edge is registered,
// decoded and executed in the next cycle. Its result appears on out_res with
// out_valid high for exactly one cycle once the result register is loaded, and
// is taken at the edge that ends that cycle.
// A new request may be issued every cycle; busy stays low, since each access
// finishes in the single execute stage (command table lookup plus one
// 10x6 multiply for the Read Data sector address). The receiver must take
// each result in the cycle it is shown. Motor and DMA interrupt enable bits
// of the control port affect no output and are not stored.
module floppy_controller_command_result_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  fdc_pkg::req_t in_req,
  output logic          out_valid,
  output fdc_pkg::res_t out_res,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data
);

  // Request register
  logic          in_vld_r;
  fdc_pkg::req_t in_req_r;

  // Result register
  logic          out_vld_r;
  fdc_pkg::res_t out_res_r;
  fdc_pkg::res_t out_res_nxt;

  // Controller state
  fdc_pkg::phase_t                    phase_r, phase_nxt;
  logic [3:0]                         bi_r, bi_nxt;
  logic [4:0]                         code_r, code_nxt;
  logic [7:0]                         cmd_r [0:fdc_pkg::CMD_DEPTH-1];
  logic [fdc_pkg::RES_DEPTH-1:0][7:0] rb_r, rb_nxt;
  logic [7:0]                         ms_r, ms_nxt;
  logic [7:0]                         pcyl_r, pcyl_nxt;
  logic [1:0]                         dsel_r, dsel_nxt;
  logic                               irq_r, irq_nxt;
  logic                               sheld_r, sheld_nxt;
  logic                               hheld_r, hheld_nxt;
  logic [fdc_pkg::IMG_AW-1:0]         ptr_r, ptr_nxt;
  logic [5:0]                         spt_r;
  logic [7:0]                         cyl_r;

  // Data-port write path
  logic       is_wr;
  logic [7:0] d;
  logic       dw;
  logic [4:0] dw_code;
  logic [3:0] dw_bi;
  logic [3:0] dw_bi_inc;
  logic       dw_done;
  logic       cmd_we;
  logic [7:0] view_c, view_h, view_r, view_n;
  logic [3:0] rd_bi_inc;

  fdc_pkg::exec_t ex;

  assign busy      = 1'b0;
  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

  assign is_wr = (in_req_r.opcode == fdc_pkg::OP_WRITE);
  assign d     = in_req_r.write_data;

  // Command byte collection
  assign dw = in_vld_r && is_wr && (in_req_r.port == fdc_pkg::P_DATA) &&
              ((phase_r == fdc_pkg::PH_IDLE) || (phase_r == fdc_pkg::PH_COMMAND));
  assign dw_code   = (phase_r == fdc_pkg::PH_IDLE) ? d[4:0] : code_r;
  assign dw_bi     = (phase_r == fdc_pkg::PH_IDLE) ? 4'd0 : bi_r;
  assign dw_bi_inc = dw_bi + 4'd1;
  assign dw_done   = (dw_bi_inc == fdc_pkg::wr_len(dw_code));
  assign cmd_we    = dw && (dw_bi < 4'(fdc_pkg::CMD_DEPTH));

  // Command bytes as they stand after this write
  assign view_c = (cmd_we && dw_bi == 4'd2) ? d : cmd_r[2];
  assign view_h = (cmd_we && dw_bi == 4'd3) ? d : cmd_r[3];
  assign view_r = (cmd_we && dw_bi == 4'd4) ? d : cmd_r[4];
  assign view_n = (cmd_we && dw_bi == 4'd5) ? d : cmd_r[5];

  assign rd_bi_inc = bi_r + 4'd1;

  fdc_exec u_exec (
    .code      (dw_code),
    .spt       (spt_r),
    .cyl_count (cyl_r),
    .dsel      (dsel_r),
    .pcyl      (pcyl_r),
    .res_cur   (rb_r),
    .byte_c    (view_c),
    .byte_h    (view_h),
    .byte_r    (view_r),
    .byte_n    (view_n),
    .ex        (ex)
  );

  // Access decode and state update
  always_comb begin
    phase_nxt = phase_r;
    bi_nxt    = bi_r;
    code_nxt  = code_r;
    rb_nxt    = rb_r;
    ms_nxt    = ms_r;
    pcyl_nxt  = pcyl_r;
    dsel_nxt  = dsel_r;
    irq_nxt   = irq_r;
    sheld_nxt = sheld_r;
    hheld_nxt = hheld_r;
    ptr_nxt   = ptr_r;
    out_res_nxt = '0;
    if (in_vld_r) begin
      if (is_wr) begin
        case (in_req_r.port)
          fdc_pkg::P_CTRL: begin
            dsel_nxt = d[1:0];
            if (d[2]) begin
              if (sheld_r) begin
                dsel_nxt  = 2'd0;
                ms_nxt    = fdc_pkg::MS_RQM;
                bi_nxt    = 4'd0;
                phase_nxt = fdc_pkg::PH_IDLE;
                sheld_nxt = 1'b0;
                irq_nxt   = 1'b1;
              end
            end else if (!sheld_r) begin
              sheld_nxt = 1'b1;
              irq_nxt   = 1'b0;
            end
          end
          fdc_pkg::P_STAT: begin
            if (d[6]) begin
              if (!hheld_r) begin
                hheld_nxt = 1'b1;
                irq_nxt   = 1'b0;
              end
            end else if (hheld_r) begin
              dsel_nxt  = 2'd0;
              ms_nxt    = fdc_pkg::MS_RQM;
              bi_nxt    = 4'd0;
              phase_nxt = fdc_pkg::PH_IDLE;
              hheld_nxt = 1'b0;
            end
          end
          fdc_pkg::P_DATA: begin
            if (dw) begin
              code_nxt  = dw_code;
              phase_nxt = fdc_pkg::PH_COMMAND;
              bi_nxt    = dw_bi_inc;
              if (dw_done) begin
                rb_nxt   = ex.res_bytes;
                pcyl_nxt = ex.pcyl;
                if (ex.ptr_load) begin
                  ptr_nxt = ex.ptr;
                end
                if (fdc_pkg::rd_len(dw_code) != 3'd0) begin
                  ms_nxt    = ms_r | fdc_pkg::MS_DIO;
                  phase_nxt = fdc_pkg::PH_RESULT;
                end else begin
                  phase_nxt = fdc_pkg::PH_IDLE;
                end
                bi_nxt = 4'd0;
              end
            end
          end
          default: begin
          end
        endcase
      end else begin
        out_res_nxt.claimed = 1'b1;
        case (in_req_r.port)
          fdc_pkg::P_ID:   out_res_nxt.read_data = fdc_pkg::ID_VALUE;
          fdc_pkg::P_DMA0, fdc_pkg::P_DMA1: begin
            out_res_nxt.disk_fetch   = 1'b1;
            out_res_nxt.disk_address = ptr_r;
            ptr_nxt = ptr_r + fdc_pkg::IMG_AW'(1);
          end
          fdc_pkg::P_CTRL: out_res_nxt.read_data = fdc_pkg::CTRL_READ;
          fdc_pkg::P_IRQ:  out_res_nxt.read_data = irq_r ? fdc_pkg::IRQ_READ : 8'h00;
          fdc_pkg::P_STAT: out_res_nxt.read_data = ms_r;
          fdc_pkg::P_DATA: begin
            // result byte hand-out; outside the result phase reads 0
            if (phase_r == fdc_pkg::PH_RESULT) begin
              if (bi_r < 4'(fdc_pkg::RES_DEPTH)) begin
                out_res_nxt.read_data = rb_r[bi_r[2:0]];
              end
              if (rd_bi_inc == {1'b0, fdc_pkg::rd_len(code_r)}) begin
                bi_nxt    = 4'd0;
                phase_nxt = fdc_pkg::PH_IDLE;
                ms_nxt    = (ms_r & ~fdc_pkg::MS_DIO) | fdc_pkg::MS_RQM;
              end else begin
                bi_nxt = rd_bi_inc;
              end
            end
          end
          fdc_pkg::P_ZERO: out_res_nxt.read_data = 8'h00;
          default: out_res_nxt.claimed = 1'b0;
        endcase
      end
    end
    out_res_nxt.irq_line = irq_nxt;
  end

  // Request and result registers
  always_ff @(posedge clk) begin
    in_req_r  <= in_req;
    out_res_r <= out_res_nxt;
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
    end
  end

  // Command byte store, no reset
  always_ff @(posedge clk) begin
    if (cmd_we) begin
      cmd_r[dw_bi] <= d;
    end
  end

  // Controller state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fdc_pkg::PH_IDLE;
      bi_r    <= 4'd0;
      code_r  <= 5'd0;
      rb_r    <= '0;
      ms_r    <= fdc_pkg::MS_RQM;
      pcyl_r  <= 8'd0;
      dsel_r  <= 2'd0;
      irq_r   <= 1'b0;
      sheld_r <= 1'b0;
      hheld_r <= 1'b0;
      ptr_r   <= '0;
      spt_r   <= fdc_pkg::SPT_RESET;
      cyl_r   <= fdc_pkg::CYL_RESET;
    end else begin
      phase_r <= phase_nxt;
      bi_r    <= bi_nxt;
      code_r  <= code_nxt;
      rb_r    <= rb_nxt;
      ms_r    <= ms_nxt;
      pcyl_r  <= pcyl_nxt;
      dsel_r  <= dsel_nxt;
      irq_r   <= irq_nxt;
      sheld_r <= sheld_nxt;
      hheld_r <= hheld_nxt;
      ptr_r   <= ptr_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fdc_pkg::CFG_SPT: spt_r <= cfg_data[5:0];
          fdc_pkg::CFG_CYL: cyl_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule
